// File: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clk edge outside reset
`define CDTT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in one cycle implies a condition in the next
`define CDTT_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/cdtt_pkg.sv
// shared types, constants and codes of the countdown timer table
package cdtt_pkg;

  localparam int NUM_TIMERS  = 8;
  localparam int MAX_RESULTS = 8;

  localparam int CMD_W     = 3;
  localparam int SLOT_W    = 3;
  localparam int TIME_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int IDX_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int IDX_EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam int FIRE_W    = $clog2(MAX_RESULTS + 1);

  localparam logic [TIME_W-1:0] TICK_PERIOD_RESET = TIME_W'(1000);

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE = 3'd0,
    CMD_START  = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_RELOAD = 3'd3,
    CMD_TICK   = 3'd4
  } cmd_t;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_USED = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_DEC    = 3'd1,
    OP_CLAIM  = 3'd2,
    OP_FIRE   = 3'd3,
    OP_START  = 3'd4,
    OP_STOP   = 3'd5,
    OP_RELOAD = 3'd6
  } cell_op_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    cell_op_t            op;
    logic                go;
    logic                adv;
    logic                clr;
    logic                seed;
    logic [SLOT_W-1:0]   slot;
    logic [TIME_W-1:0]   timeout;
    logic                periodic;
    logic [TIME_W-1:0]   tick_period;
  } cell_ctl_t;

endpackage

// File: rtl/cdtt_in_if.sv
// command channel: valid, ready and one command item
interface cdtt_in_if;
  logic                         valid;
  logic                         ready;
  logic [cdtt_pkg::CMD_W-1:0]   cmd;
  logic [cdtt_pkg::SLOT_W-1:0]  slot;
  logic [cdtt_pkg::TIME_W-1:0]  timeout;
  logic                         periodic;

  modport source (output valid, cmd, slot, timeout, periodic, input ready);
  modport sink   (input valid, cmd, slot, timeout, periodic, output ready);
endinterface

// File: rtl/cdtt_out_if.sv
// result channel: valid, ready and one result item
interface cdtt_out_if;
  logic                           valid;
  logic                           ready;
  logic [cdtt_pkg::SLOT_W-1:0]    slot_out;
  logic [cdtt_pkg::STATUS_W-1:0]  status;
  logic                           fired;
  logic                           last;

  modport source (output valid, slot_out, status, fired, last, input ready);
  modport sink   (input valid, slot_out, status, fired, last, output ready);
endinterface

// File: rtl/cdtt_cell.sv
// one timer slot of the chain, with its scan token stage
module cdtt_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [cdtt_pkg::IDX_W-1:0]  cell_idx,
  input  cdtt_pkg::cell_ctl_t         ctl,
  input  logic                        tok_in,
  output logic                        tok_out,
  output logic                        hit
);

  localparam int EW = cdtt_pkg::IDX_EXT_W;

  logic                          in_use_r, in_use_nxt;
  logic                          running_r, running_nxt;
  logic                          reloads_r, reloads_nxt;
  logic                          tok_r, tok_nxt;
  logic [cdtt_pkg::TIME_W-1:0]   rem_r, rem_nxt;
  logic [cdtt_pkg::TIME_W-1:0]   rv_r, rv_nxt;
  logic                          match;
  logic                          rem_zero;
  logic                          act;

  assign match    = (EW'(ctl.slot) == EW'(cell_idx));
  assign rem_zero = (rem_r == '0);

  always_comb begin
    case (ctl.op)
      cdtt_pkg::OP_CLAIM:  hit = tok_r && !in_use_r;
      cdtt_pkg::OP_FIRE:   hit = tok_r && in_use_r && rem_zero;
      cdtt_pkg::OP_START,
      cdtt_pkg::OP_STOP,
      cdtt_pkg::OP_RELOAD: hit = match && in_use_r;
      default:             hit = 1'b0;
    endcase
  end

  assign act = ctl.go && hit;

  always_comb begin
    in_use_nxt  = in_use_r;
    running_nxt = running_r;
    reloads_nxt = reloads_r;
    rem_nxt     = rem_r;
    rv_nxt      = rv_r;
    case (ctl.op)
      cdtt_pkg::OP_DEC: begin
        if (ctl.go && in_use_r && running_r && !rem_zero) begin
          rem_nxt = (rem_r > ctl.tick_period) ? rem_r - ctl.tick_period : '0;
        end
      end
      cdtt_pkg::OP_CLAIM: begin
        if (act) begin
          in_use_nxt  = 1'b1;
          running_nxt = 1'b0;
          reloads_nxt = ctl.periodic;
          rem_nxt     = ctl.timeout;
          rv_nxt      = ctl.timeout;
        end
      end
      cdtt_pkg::OP_FIRE: begin
        if (act) begin
          if (reloads_r) begin
            rem_nxt = rv_r;
          end else begin
            in_use_nxt  = 1'b0;
            running_nxt = 1'b0;
            reloads_nxt = 1'b0;
          end
        end
      end
      cdtt_pkg::OP_START:  if (act) running_nxt = 1'b1;
      cdtt_pkg::OP_STOP:   if (act) running_nxt = 1'b0;
      cdtt_pkg::OP_RELOAD: if (act && reloads_r) rem_nxt = rv_r;
      default: ;
    endcase
  end

  always_comb begin
    tok_nxt = tok_r;
    if (ctl.clr) begin
      tok_nxt = 1'b0;
    end else if (ctl.adv) begin
      tok_nxt = tok_in;
    end
  end

  assign tok_out = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r  <= 1'b0;
      running_r <= 1'b0;
      reloads_r <= 1'b0;
      tok_r     <= 1'b0;
    end else begin
      in_use_r  <= in_use_nxt;
      running_r <= running_nxt;
      reloads_r <= reloads_nxt;
      tok_r     <= tok_nxt;
    end
  end

  // count and reload value are only read while the slot is in use
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    rv_r  <= rv_nxt;
  end

endmodule

// File: rtl/countdown_timer_table.sv
// top level of the countdown timer table: sequencer, result staging and the cell chain
//
//  channel   dir  signals                                 transfer when
//  in_ch     in   cmd, slot, timeout, periodic            in_ch.valid && in_ch.ready
//  out_ch    out  slot_out, status, fired, last           out_ch.valid && out_ch.ready
//  cfg       in   cfg_we, cfg_wdata (tick_period)         cfg_we high at the clock edge
//
// start, stop and reload go from idle straight to exec; create and tick pass through prep, scan and flush
// create and tick use a scan token that walks the cell chain one cell per cycle while the scan is not held
// one item at a time: a new command is taken once the previous one is through the sequencer
// reset is synchronous and clears every slot at once; there is no clearing pass
// a stalled result channel holds the scan on the cell that wants to report while a held-back result waits
`include "assert_macros.svh"

module countdown_timer_table (
  input  logic                         clk,
  input  logic                         rst_n,
  cdtt_in_if.sink                      in_ch,
  cdtt_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [cdtt_pkg::TIME_W-1:0]  cfg_wdata
);

  localparam int N  = cdtt_pkg::NUM_TIMERS;
  localparam int IW = cdtt_pkg::IDX_W;
  localparam int EW = cdtt_pkg::IDX_EXT_W;
  localparam int FW = cdtt_pkg::FIRE_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PREP  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_FLUSH = 5'b01000,
    ST_EXEC  = 5'b10000
  } state_t;

  state_t                            state_r, state_nxt;

  // tick period register
  logic [cdtt_pkg::TIME_W-1:0]       tick_period_r;

  // latched command
  logic [cdtt_pkg::CMD_W-1:0]        cmd_r, cmd_nxt;
  logic [cdtt_pkg::SLOT_W-1:0]       slot_r, slot_nxt;
  logic [cdtt_pkg::TIME_W-1:0]       timeout_r, timeout_nxt;
  logic                              periodic_r, periodic_nxt;

  // scan position and fire count
  logic [IW-1:0]                     idx_r, idx_nxt;
  logic [FW-1:0]                     fire_cnt_r, fire_cnt_nxt;
  logic [EW-1:0]                     idx_ext;

  // one held-back result so the final one can carry last
  logic                              pend_v_r, pend_v_nxt;
  logic [cdtt_pkg::SLOT_W-1:0]       pend_slot_r, pend_slot_nxt;
  logic                              pend_fired_r, pend_fired_nxt;

  // output register
  logic                              out_valid_r, out_valid_nxt;
  logic [cdtt_pkg::SLOT_W-1:0]       out_slot_r, out_slot_nxt;
  logic [cdtt_pkg::STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic                              out_fired_r, out_fired_nxt;
  logic                              out_last_r, out_last_nxt;

  cdtt_pkg::cell_ctl_t               ctl;
  logic [N-1:0]                      tok;
  logic [N-1:0]                      tok_in;
  logic [N-1:0]                      hit;
  logic                              hit_any;
  logic                              out_free;
  logic                              room;
  logic                              end_here;
  logic                              is_create;
  logic                              accept;

  assign hit_any   = |hit;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign room      = !pend_v_r || out_free;
  assign end_here  = (idx_r == IW'(N - 1));
  assign is_create = (cmd_r == cdtt_pkg::CMD_CREATE);
  assign idx_ext   = EW'(idx_r);

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // cell chain: the token enters at cell 0 and moves one cell per advance
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign tok_in[i] = ctl.seed;
    end else begin : g_link
      assign tok_in[i] = tok[i-1];
    end
    cdtt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IW'(i)),
      .ctl      (ctl),
      .tok_in   (tok_in[i]),
      .tok_out  (tok[i]),
      .hit      (hit[i])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    slot_nxt       = slot_r;
    timeout_nxt    = timeout_r;
    periodic_nxt   = periodic_r;
    idx_nxt        = idx_r;
    fire_cnt_nxt   = fire_cnt_r;
    pend_v_nxt     = pend_v_r;
    pend_slot_nxt  = pend_slot_r;
    pend_fired_nxt = pend_fired_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    out_fired_nxt  = out_fired_r;
    out_last_nxt   = out_last_r;

    ctl.op          = cdtt_pkg::OP_NONE;
    ctl.go          = 1'b0;
    ctl.adv         = 1'b0;
    ctl.clr         = 1'b0;
    ctl.seed        = 1'b0;
    ctl.slot        = slot_r;
    ctl.timeout     = timeout_r;
    ctl.periodic    = periodic_r;
    ctl.tick_period = tick_period_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt      = in_ch.cmd;
          slot_nxt     = in_ch.slot;
          timeout_nxt  = in_ch.timeout;
          periodic_nxt = in_ch.periodic;
          case (in_ch.cmd)
            cdtt_pkg::CMD_CREATE,
            cdtt_pkg::CMD_TICK:   state_nxt = ST_PREP;
            cdtt_pkg::CMD_START,
            cdtt_pkg::CMD_STOP,
            cdtt_pkg::CMD_RELOAD: state_nxt = ST_EXEC;
            default:              state_nxt = ST_IDLE; // unknown codes are dropped
          endcase
        end
      end

      ST_PREP: begin
        // tick lowers every running count here; both commands seed the token
        ctl.op       = is_create ? cdtt_pkg::OP_NONE : cdtt_pkg::OP_DEC;
        ctl.go       = 1'b1;
        ctl.adv      = 1'b1;
        ctl.seed     = 1'b1;
        idx_nxt      = '0;
        fire_cnt_nxt = '0;
        state_nxt    = ST_SCAN;
      end

      ST_SCAN: begin
        ctl.op = is_create ? cdtt_pkg::OP_CLAIM : cdtt_pkg::OP_FIRE;
        if (hit_any) begin
          if (room) begin
            ctl.go = 1'b1;
            // push the previous held result out, not last
            if (pend_v_r) begin
              out_valid_nxt  = 1'b1;
              out_slot_nxt   = pend_slot_r;
              out_status_nxt = cdtt_pkg::STATUS_OK;
              out_fired_nxt  = pend_fired_r;
              out_last_nxt   = 1'b0;
            end
            pend_v_nxt     = 1'b1;
            pend_slot_nxt  = idx_ext[cdtt_pkg::SLOT_W-1:0];
            pend_fired_nxt = !is_create;
            fire_cnt_nxt   = fire_cnt_r + FW'(1);
            if (is_create || end_here ||
                (fire_cnt_r == FW'(cdtt_pkg::MAX_RESULTS - 1))) begin
              ctl.clr   = 1'b1;
              state_nxt = ST_FLUSH;
            end else begin
              ctl.adv = 1'b1;
              idx_nxt = idx_r + IW'(1);
            end
          end
        end else if (end_here) begin
          ctl.clr   = 1'b1;
          state_nxt = ST_FLUSH;
        end else begin
          ctl.adv = 1'b1;
          idx_nxt = idx_r + IW'(1);
        end
      end

      ST_FLUSH: begin
        if (pend_v_r) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_slot_nxt   = pend_slot_r;
            out_status_nxt = cdtt_pkg::STATUS_OK;
            out_fired_nxt  = pend_fired_r;
            out_last_nxt   = 1'b1;
            pend_v_nxt     = 1'b0;
            state_nxt      = ST_IDLE;
          end
        end else if (is_create) begin
          // no free slot found
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_slot_nxt   = '0;
            out_status_nxt = cdtt_pkg::STATUS_FULL;
            out_fired_nxt  = 1'b0;
            out_last_nxt   = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end else begin
          // tick with nothing expired gives no result
          state_nxt = ST_IDLE;
        end
      end

      ST_EXEC: begin
        case (cmd_r)
          cdtt_pkg::CMD_START: ctl.op = cdtt_pkg::OP_START;
          cdtt_pkg::CMD_STOP:  ctl.op = cdtt_pkg::OP_STOP;
          default:             ctl.op = cdtt_pkg::OP_RELOAD;
        endcase
        if (out_free) begin
          ctl.go         = 1'b1;
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = slot_r;
          out_status_nxt = hit_any ? cdtt_pkg::STATUS_OK : cdtt_pkg::STATUS_NOT_USED;
          out_fired_nxt  = 1'b0;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      tick_period_r <= cdtt_pkg::TICK_PERIOD_RESET;
      pend_v_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      idx_r         <= '0;
      fire_cnt_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      fire_cnt_r  <= fire_cnt_nxt;
      if (cfg_we) begin
        tick_period_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    slot_r       <= slot_nxt;
    timeout_r    <= timeout_nxt;
    periodic_r   <= periodic_nxt;
    pend_slot_r  <= pend_slot_nxt;
    pend_fired_r <= pend_fired_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
    out_fired_r  <= out_fired_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.slot_out = out_slot_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.fired    = out_fired_r;
  assign out_ch.last     = out_last_r;

  // at most one cell carries the scan token
  `CDTT_ASSERT(a_tok_onehot, $onehot0(tok), "more than one scan token in the chain")
  // only one cell may answer a scan or an addressed command
  `CDTT_ASSERT(a_hit_onehot, $onehot0(hit), "several cells answered at once")
  // nothing is left in the chain or held back once the sequencer is idle
  `CDTT_ASSERT(a_idle_clean, (state_r == ST_IDLE) |-> (tok == '0) && !pend_v_r,
               "token or held result left over in idle")
  // the per-tick expiry limit is never passed
  `CDTT_ASSERT(a_fire_cap, fire_cnt_r <= FW'(cdtt_pkg::MAX_RESULTS),
               "more expirations than allowed in one tick")
  // a scan that ends always moves on to flush
  `CDTT_ASSERT_NEXT(a_scan_end, (state_r == ST_SCAN) && ctl.clr, state_r == ST_FLUSH,
                    "scan ended without a flush")

endmodule

// File: tb/sv/countdown_timer_table_tb.sv
// self-checking testbench for the countdown timer table
`timescale 1ns / 1ps

module countdown_timer_table_tb;

  // command codes with no meaning to the block: no result, no state change
  localparam logic [cdtt_pkg::CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [cdtt_pkg::CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  // a tick scans every cell once, plus the sequencer's own states
  localparam int DRAIN_CYCLES = cdtt_pkg::NUM_TIMERS + 8;
  // long enough that the one-item pipeline backs up into the command channel
  localparam int HOLD_CYCLES  = 80;
  localparam int IDLE_PCT     = 14;
  localparam longint LIMIT_NS = 64'd10_000_000;

  typedef struct packed {
    logic [cdtt_pkg::CMD_W-1:0]  cmd;
    logic [cdtt_pkg::SLOT_W-1:0] slot;
    logic [cdtt_pkg::TIME_W-1:0] timeout;
    logic                        periodic;
  } timer_cmd_t;

  typedef struct packed {
    logic [cdtt_pkg::SLOT_W-1:0]   slot_out;
    logic [cdtt_pkg::STATUS_W-1:0] status;
    logic                          fired;
    logic                          last;
  } timer_result_t;

  // one row of the directed table; want is used only when typed is set
  typedef struct {
    timer_cmd_t    c;
    bit            typed;
    timer_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [cdtt_pkg::TIME_W-1:0] cfg_wdata;

  cdtt_in_if  cmd_ch();
  cdtt_out_if res_ch();

  countdown_timer_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (cmd_ch),
    .out_ch    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the timer table, advanced once per accepted command
  // ---------------------------------------------------------------------------
  logic                        slot_used     [cdtt_pkg::NUM_TIMERS];
  logic                        slot_running  [cdtt_pkg::NUM_TIMERS];
  logic                        slot_periodic [cdtt_pkg::NUM_TIMERS];
  logic [cdtt_pkg::TIME_W-1:0] slot_count    [cdtt_pkg::NUM_TIMERS];
  logic [cdtt_pkg::TIME_W-1:0] slot_reload   [cdtt_pkg::NUM_TIMERS];
  logic [cdtt_pkg::TIME_W-1:0] period_now;

  timer_result_t results_due[$];   // results still owed by the block, oldest first
  int            error_count;
  bit            calm;             // both sides stop idling while set
  bit            hold_req;         // asks the result side for one long stall
  stim_row_t     plan[$];

  function automatic timer_result_t make_result(int s, logic [cdtt_pkg::STATUS_W-1:0] st,
                                                logic fd, logic lt);
    timer_result_t r;
    r.slot_out = cdtt_pkg::SLOT_W'(s);
    r.status   = st;
    r.fired    = fd;
    r.last     = lt;
    return r;
  endfunction

  function automatic void clear_slot(int s);
    slot_used[s]     = 1'b0;
    slot_running[s]  = 1'b0;
    slot_periodic[s] = 1'b0;
    slot_count[s]    = '0;
    slot_reload[s]   = '0;
  endfunction

  // applies one command to the shadow table and lists the results it causes
  function automatic void step_timers(timer_cmd_t c, ref timer_result_t outq[$]);
    int s;
    outq.delete();
    if (c.cmd == cdtt_pkg::CMD_CREATE) begin
      s = 0;
      while (s < cdtt_pkg::NUM_TIMERS && slot_used[s]) s++;
      if (s == cdtt_pkg::NUM_TIMERS) begin
        // table full: nothing changes
        outq.push_back(make_result(0, cdtt_pkg::STATUS_FULL, 1'b0, 1'b1));
      end else begin
        slot_used[s]     = 1'b1;
        slot_running[s]  = 1'b0;
        slot_periodic[s] = c.periodic;
        slot_count[s]    = c.timeout;
        slot_reload[s]   = c.timeout;
        outq.push_back(make_result(s, cdtt_pkg::STATUS_OK, 1'b0, 1'b1));
      end
    end else if (c.cmd == cdtt_pkg::CMD_START || c.cmd == cdtt_pkg::CMD_STOP ||
                 c.cmd == cdtt_pkg::CMD_RELOAD) begin
      s = int'(c.slot);
      if (s >= cdtt_pkg::NUM_TIMERS || !slot_used[s]) begin
        outq.push_back(make_result(s, cdtt_pkg::STATUS_NOT_USED, 1'b0, 1'b1));
      end else begin
        if (c.cmd == cdtt_pkg::CMD_START) slot_running[s] = 1'b1;
        else if (c.cmd == cdtt_pkg::CMD_STOP) slot_running[s] = 1'b0;
        else if (slot_periodic[s]) slot_count[s] = slot_reload[s];
        outq.push_back(make_result(s, cdtt_pkg::STATUS_OK, 1'b0, 1'b1));
      end
    end else if (c.cmd == cdtt_pkg::CMD_TICK) begin
      // count down first, saturating at zero
      for (s = 0; s < cdtt_pkg::NUM_TIMERS; s++) begin
        if (slot_used[s] && slot_running[s] && slot_count[s] != '0) begin
          slot_count[s] = (slot_count[s] > period_now) ? slot_count[s] - period_now : '0;
        end
      end
      // then every used slot at zero fires, running or not, lowest first
      for (s = 0; s < cdtt_pkg::NUM_TIMERS && outq.size() < cdtt_pkg::MAX_RESULTS; s++) begin
        if (slot_used[s] && slot_count[s] == '0) begin
          if (slot_periodic[s]) slot_count[s] = slot_reload[s];
          else clear_slot(s);
          outq.push_back(make_result(s, cdtt_pkg::STATUS_OK, 1'b1, 1'b0));
        end
      end
      if (outq.size() > 0) outq[outq.size()-1].last = 1'b1;
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $time, what);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // result side: ready with random gaps, one long hold on request
  // ---------------------------------------------------------------------------
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      res_ch.ready <= rst_n && (calm || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // every result transfer is checked against the oldest owed result
  always @(posedge clk) begin
    timer_result_t got;
    timer_result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got = {res_ch.slot_out, res_ch.status, res_ch.fired, res_ch.last};
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result slot %0d status %0d fired %0d last %0d",
                                  got.slot_out, got.status, got.fired, got.last));
      end else begin
        want = results_due.pop_front();
        if (got !== want)
          report_mismatch($sformatf(
            "got slot %0d status %0d fired %0d last %0d, want %0d %0d %0d %0d",
            got.slot_out, got.status, got.fired, got.last,
            want.slot_out, want.status, want.fired, want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------------

  // offers one command, waits for its transfer, then books what it should produce
  task automatic issue_command(timer_cmd_t c, bit typed, timer_result_t typed_res);
    timer_result_t fresh[$];
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.cmd      <= c.cmd;
    cmd_ch.slot     <= c.slot;
    cmd_ch.timeout  <= c.timeout;
    cmd_ch.periodic <= c.periodic;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    // valid stays up here; the next call or settle() decides what follows
    step_timers(c, fresh);
    if (typed) results_due.push_back(typed_res);
    else foreach (fresh[i]) results_due.push_back(fresh[i]);
  endtask

  // drop valid, wait out every owed result, then give a silent command time to finish
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tick_period(logic [cdtt_pkg::TIME_W-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    period_now = v;
  endtask

  task automatic add_row(logic [cdtt_pkg::CMD_W-1:0] cmd, int slot,
                         logic [cdtt_pkg::TIME_W-1:0] timeout,
                         logic periodic, bit typed, int want_slot,
                         logic [cdtt_pkg::STATUS_W-1:0] want_status);
    stim_row_t r;
    r.c.cmd      = cmd;
    r.c.slot     = cdtt_pkg::SLOT_W'(slot);
    r.c.timeout  = timeout;
    r.c.periodic = periodic;
    r.typed      = typed;
    r.want       = make_result(want_slot, want_status, 1'b0, 1'b1);
    plan.push_back(r);
  endtask

  // timeouts mostly a few ticks long so that timers actually expire
  function automatic logic [cdtt_pkg::TIME_W-1:0] pick_timeout();
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 8) return '0;
    if (w < 12) return '1;
    if (w < 24) return cdtt_pkg::TIME_W'($urandom);
    return cdtt_pkg::TIME_W'(period_now * $urandom_range(1, 4)) +
           cdtt_pkg::TIME_W'($urandom_range(0, 2));
  endfunction

  function automatic timer_cmd_t pick_command();
    timer_cmd_t c;
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 4) c.cmd = cdtt_pkg::CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    else if (w < 28) c.cmd = cdtt_pkg::CMD_CREATE;
    else if (w < 50) c.cmd = cdtt_pkg::CMD_START;
    else if (w < 60) c.cmd = cdtt_pkg::CMD_STOP;
    else if (w < 68) c.cmd = cdtt_pkg::CMD_RELOAD;
    else c.cmd = cdtt_pkg::CMD_TICK;
    // unused fields are randomized too so every input bit toggles
    c.slot     = cdtt_pkg::SLOT_W'($urandom_range(0, cdtt_pkg::NUM_TIMERS - 1));
    c.timeout  = pick_timeout();
    c.periodic = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // random commands; unknown codes do not count toward the total
  task automatic random_burst(int count);
    timer_cmd_t c;
    int taken;
    taken = 0;
    while (taken < count) begin
      c = pick_command();
      issue_command(c, 1'b0, '0);
      if (c.cmd < CMD_UNUSED_LO) taken++;
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.cmd       = '0;
    cmd_ch.slot      = '0;
    cmd_ch.timeout   = '0;
    cmd_ch.periodic  = 1'b0;
    calm             = 1'b0;
    hold_req         = 1'b0;
    error_count      = 0;
    period_now       = cdtt_pkg::TICK_PERIOD_RESET;
    for (int s = 0; s < cdtt_pkg::NUM_TIMERS; s++) clear_slot(s);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, tick_period at its reset value
    // addressing an empty table
    add_row(cdtt_pkg::CMD_START,  0, '0, 1'b0, 1'b1, 0, cdtt_pkg::STATUS_NOT_USED);
    add_row(cdtt_pkg::CMD_STOP,   7, '1, 1'b1, 1'b1, 7, cdtt_pkg::STATUS_NOT_USED);
    add_row(cdtt_pkg::CMD_RELOAD, 3, '0, 1'b0, 1'b1, 3, cdtt_pkg::STATUS_NOT_USED);
    add_row(cdtt_pkg::CMD_TICK,   5, '1, 1'b1, 1'b0, 0, cdtt_pkg::STATUS_OK); // nothing fires
    // creates at the timeout extremes; zero one-shot fires while halted
    add_row(cdtt_pkg::CMD_CREATE, 2, '0,       1'b0, 1'b1, 0, cdtt_pkg::STATUS_OK);
    add_row(cdtt_pkg::CMD_CREATE, 6, '1,       1'b1, 1'b1, 1, cdtt_pkg::STATUS_OK);
    add_row(cdtt_pkg::CMD_CREATE, 1, 32'd1000, 1'b1, 1'b1, 2, cdtt_pkg::STATUS_OK);
    add_row(cdtt_pkg::CMD_CREATE, 4, 32'd2500, 1'b0, 1'b1, 3, cdtt_pkg::STATUS_OK);
    add_row(cdtt_pkg::CMD_CREATE, 0, '0,       1'b1, 1'b1, 4, cdtt_pkg::STATUS_OK); // every tick
    add_row(cdtt_pkg::CMD_START,  1, '0, 1'b0, 1'b1, 1, cdtt_pkg::STATUS_OK);
    add_row(cdtt_pkg::CMD_START,  2, '0, 1'b0, 1'b1, 2, cdtt_pkg::STATUS_OK);
    add_row(cdtt_pkg::CMD_START,  3, '0, 1'b0, 1'b1, 3, cdtt_pkg::STATUS_OK);
    add_row(cdtt_pkg::CMD_TICK,   0, '0, 1'b0, 1'b0, 0, cdtt_pkg::STATUS_OK);
    // reload of a one-shot slot changes nothing, of a periodic one restores it
    add_row(cdtt_pkg::CMD_RELOAD, 3, '0, 1'b0, 1'b1, 3, cdtt_pkg::STATUS_OK);
    add_row(cdtt_pkg::CMD_RELOAD, 1, '0, 1'b0, 1'b1, 1, cdtt_pkg::STATUS_OK);
    add_row(cdtt_pkg::CMD_STOP,   2, '0, 1'b0, 1'b1, 2, cdtt_pkg::STATUS_OK);
    // freed slot 0 is reused first, then fill the table and overflow it
    add_row(cdtt_pkg::CMD_CREATE, 7, 32'd5,    1'b1, 1'b1, 0, cdtt_pkg::STATUS_OK);
    add_row(cdtt_pkg::CMD_CREATE, 3, 32'd3000, 1'b1, 1'b1, 5, cdtt_pkg::STATUS_OK);
    add_row(cdtt_pkg::CMD_CREATE, 5, '0,       1'b0, 1'b1, 6, cdtt_pkg::STATUS_OK);
    add_row(cdtt_pkg::CMD_CREATE, 2, 32'd1,    1'b0, 1'b1, 7, cdtt_pkg::STATUS_OK);
    add_row(cdtt_pkg::CMD_CREATE, 1, 32'd77,   1'b1, 1'b1, 0, cdtt_pkg::STATUS_FULL);
    // unknown codes are silent
    add_row(CMD_UNUSED_LO, 6, '1, 1'b1, 1'b0, 0, cdtt_pkg::STATUS_OK);
    add_row(CMD_UNUSED_HI, 1, '0, 1'b0, 1'b0, 0, cdtt_pkg::STATUS_OK);
    add_row(cdtt_pkg::CMD_START,  7, '0, 1'b0, 1'b1, 7, cdtt_pkg::STATUS_OK);
    add_row(cdtt_pkg::CMD_TICK,   3, '0, 1'b1, 1'b0, 0, cdtt_pkg::STATUS_OK);
    foreach (plan[i]) issue_command(plan[i].c, plan[i].typed, plan[i].want);

    // smallest period: counts crawl down
    write_tick_period(32'd1);
    random_burst(60);

    // largest period, and a stretch where neither side idles
    write_tick_period('1);
    calm = 1'b1;
    random_burst(60);
    calm = 1'b0;

    // zero period: running counts stay put, only zero counts fire
    write_tick_period('0);
    random_burst(30);

    // result side holds off while commands keep coming, so the block backs up
    write_tick_period(cdtt_pkg::TIME_W'($urandom_range(1, 5000)));
    hold_req = 1'b1;
    random_burst(60);

    write_tick_period(cdtt_pkg::TICK_PERIOD_RESET);
    random_burst(50);

    write_tick_period(cdtt_pkg::TIME_W'($urandom));
    random_burst(40);

    settle();
    if (error_count == 0) begin
      $display("[countdown_timer_table] OK");
    end else begin
      $display("[countdown_timer_table] ERROR");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #(LIMIT_NS);
    $display("[countdown_timer_table] ERROR");
    $finish;
  end

endmodule
